// ===== design/hpst_pkg.sv =====
// Package for the half-edge point side test: shared constants and the
// control struct that travels down the pipeline. No dependencies.
`default_nettype none

package hpst_pkg;

    localparam int DEFAULT_COORD_WIDTH = 32;

    localparam int COEF_WIDTH  = 32;
    localparam int CONST_WIDTH = 48;
    localparam int FRAC_SHIFT  = 30;   // Q2.30 coefficient scale
    localparam int BIAS_SHIFT  = 60;   // square of the coefficient scale
    localparam int BIAS_WIDTH  = 64;

    localparam logic signed [COEF_WIDTH-1:0] A_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic quick;     // decided by the x comparison alone
        logic qval;
        logic rs;        // point right of top site
        logic side;
        logic aone;      // a equals one
        logic negb;
        logic dxs_nz;
        logic fast;      // a fast test settles it
        logic above_f;
    } t_ctl;

endpackage

`default_nettype wire

// ===== design/hpst_req_if.sv =====
// Input channel of the half-edge point side test.
// Depends on hpst_pkg.
`default_nettype none

interface hpst_req_if #(
    parameter int COORD_WIDTH = hpst_pkg::DEFAULT_COORD_WIDTH
);
    import hpst_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] top_site_x;
    logic signed [COORD_WIDTH-1:0] top_site_y;
    logic signed [COORD_WIDTH-1:0] left_site_x;
    logic signed [COEF_WIDTH-1:0]  line_a;
    logic signed [COEF_WIDTH-1:0]  line_b;
    logic signed [CONST_WIDTH-1:0] line_c;
    logic                          edge_side;

    modport source (
        output valid, point_x, point_y, top_site_x, top_site_y, left_site_x,
               line_a, line_b, line_c, edge_side,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, top_site_x, top_site_y, left_site_x,
               line_a, line_b, line_c, edge_side,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/hpst_rsp_if.sv =====
// Output channel of the half-edge point side test.
// No dependencies.
`default_nettype none

interface hpst_rsp_if;
    logic valid;
    logic ready;
    logic left_of;

    modport source (output valid, left_of, input ready);
    modport sink (input valid, left_of, output ready);
endinterface

`default_nettype wire

// ===== design/hpst_mul.sv =====
// Two-stage signed multiplier: operands split in halves, four partial
// products registered, then summed and registered. Standalone.
`default_nettype none

module hpst_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en_pp,
    input  wire logic                    i_en_sum,
    input  wire logic signed [AW-1:0]    i_a,
    input  wire logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0]      o_p
);
    localparam int HA  = AW / 2;
    localparam int HB  = BW / 2;
    localparam int PW  = AW + BW;
    localparam int LLW = HA + HB + 2;
    localparam int HLW = AW - HA + HB + 1;
    localparam int LHW = HA + BW - HB + 1;
    localparam int HHW = AW - HA + BW - HB;

    logic        [HA-1:0]    a_lo;
    logic signed [AW-HA-1:0] a_hi;
    logic        [HB-1:0]    b_lo;
    logic signed [BW-HB-1:0] b_hi;

    logic signed [LLW-1:0] n_ll, r_ll;
    logic signed [HLW-1:0] n_hl, r_hl;
    logic signed [LHW-1:0] n_lh, r_lh;
    logic signed [HHW-1:0] n_hh, r_hh;

    logic signed [PW-1:0] e_ll, e_hl, e_lh, e_hh, n_p, r_p;

    always_comb begin
        a_lo = i_a[HA-1:0];
        a_hi = i_a[AW-1:HA];
        b_lo = i_b[HB-1:0];
        b_hi = i_b[BW-1:HB];
        n_ll = LLW'($signed({1'b0, a_lo})) * LLW'($signed({1'b0, b_lo}));
        n_hl = HLW'(a_hi) * HLW'($signed({1'b0, b_lo}));
        n_lh = LHW'($signed({1'b0, a_lo})) * LHW'(b_hi);
        n_hh = HHW'(a_hi) * HHW'(b_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= n_ll;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_hh <= n_hh;
        end
    end

    always_comb begin
        e_ll = PW'(r_ll);
        e_hl = PW'(r_hl);
        e_lh = PW'(r_lh);
        e_hh = PW'(r_hh);
        n_p  = (e_hh <<< (HA + HB)) + (e_hl <<< HA) + (e_lh <<< HB) + e_ll;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== design/halfedge_point_side_test.sv =====
// Half-edge point side test, Fortune sweep predicate.
// Throughput: one transaction per cycle unless the output stalls. Stages:
// differences, product pair (2), reduction, wide product pair (2), final
// compare. Stalls back-pressure per stage, so empty stages keep accepting.
// Synchronous active-low reset clears the valid bits only. Depends on
// hpst_pkg, hpst_req_if, hpst_rsp_if, hpst_mul.
`default_nettype none

module halfedge_point_side_test #(
    parameter int COORD_WIDTH = hpst_pkg::DEFAULT_COORD_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hpst_req_if.sink   i_req,
    hpst_rsp_if.source o_rsp
);
    import hpst_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;            // coordinate differences
    localparam int EW  = DW + 2;            // dxs + 2*dxp
    localparam int D2W = 2 * DW + 1;        // dxp^2 - dyp^2
    localparam int VW  = ((DW > 50) ? DW : 50) + 32;
    localparam int F1W = DW + 33;
    localparam int F2W = ((CW + 34) > 80) ? (CW + 34) : 80;
    localparam int LA  = 2 * DW + 68;
    localparam int LB  = VW + DW + 1;
    localparam int NST = 7;

    // stage control
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || o_rsp.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_req.valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign i_req.ready = en[0];

    // stage 0: differences and flags
    logic signed [DW-1:0] px_e, py_e, tx_e, ty_e, lx_e;
    logic signed [DW-1:0] n_dxp, n_dyp, n_dxs, n_s;
    logic signed [EW-1:0] n_e;
    t_ctl                 n_c0;

    always_comb begin
        px_e  = DW'(i_req.point_x);
        py_e  = DW'(i_req.point_y);
        tx_e  = DW'(i_req.top_site_x);
        ty_e  = DW'(i_req.top_site_y);
        lx_e  = DW'(i_req.left_site_x);
        n_dxp = px_e - tx_e;
        n_dyp = py_e - ty_e;
        n_dxs = tx_e - lx_e;
        n_s   = py_e + ty_e;
        n_e   = EW'(n_dxs) + (EW'(n_dxp) <<< 1);
        n_c0         = '0;
        n_c0.rs      = i_req.point_x > i_req.top_site_x;
        n_c0.side    = i_req.edge_side;
        n_c0.quick   = n_c0.rs ^ i_req.edge_side;
        n_c0.qval    = n_c0.rs;
        n_c0.aone    = i_req.line_a == A_ONE;
        n_c0.negb    = i_req.line_b[COEF_WIDTH-1];
        n_c0.dxs_nz  = n_dxs != '0;
    end

    logic signed [DW-1:0]          r1_dxp, r1_dyp, r1_dxs, r1_s;
    logic signed [EW-1:0]          r1_e;
    logic signed [CW-1:0]          r1_px, r1_py;
    logic signed [COEF_WIDTH-1:0]  r1_a, r1_b;
    logic signed [CONST_WIDTH-1:0] r1_c;
    t_ctl                          r1_ctl;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_dxp <= n_dxp;
            r1_dyp <= n_dyp;
            r1_dxs <= n_dxs;
            r1_s   <= n_s;
            r1_e   <= n_e;
            r1_px  <= i_req.point_x;
            r1_py  <= i_req.point_y;
            r1_a   <= i_req.line_a;
            r1_b   <= i_req.line_b;
            r1_c   <= i_req.line_c;
            r1_ctl <= n_c0;
        end
    end

    // stages 1-2: first products
    logic signed [2*DW-1:0]          p_xx, p_yy, p_dsdy;
    logic signed [DW+COEF_WIDTH-1:0] p_bdx;
    logic signed [CW+COEF_WIDTH-1:0] p_pyb, p_ap;
    logic signed [2*COEF_WIDTH-1:0]  p_bb;
    logic signed [DW+EW-1:0]         p_e;

    hpst_mul #(.AW(DW), .BW(DW)) u_mxx (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_dxp), .i_b(r1_dxp), .o_p(p_xx));
    hpst_mul #(.AW(DW), .BW(DW)) u_myy (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_dyp), .i_b(r1_dyp), .o_p(p_yy));
    hpst_mul #(.AW(DW), .BW(DW)) u_mdsdy (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_dxs), .i_b(r1_dyp), .o_p(p_dsdy));
    hpst_mul #(.AW(DW), .BW(COEF_WIDTH)) u_mbdx (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_dxp), .i_b(r1_b), .o_p(p_bdx));
    hpst_mul #(.AW(CW), .BW(COEF_WIDTH)) u_mpyb (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_py), .i_b(r1_b), .o_p(p_pyb));
    hpst_mul #(.AW(CW), .BW(COEF_WIDTH)) u_map (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_px), .i_b(r1_a), .o_p(p_ap));
    hpst_mul #(.AW(COEF_WIDTH), .BW(COEF_WIDTH)) u_mbb (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_b), .i_b(r1_b), .o_p(p_bb));
    hpst_mul #(.AW(DW), .BW(EW)) u_me (
        .i_clk(i_clk), .i_en_pp(en[1]), .i_en_sum(en[2]),
        .i_a(r1_dyp), .i_b(r1_e), .o_p(p_e));

    logic signed [DW-1:0]          r2a_dyp, r2_dyp, r2a_s, r2_s;
    logic signed [CW-1:0]          r2a_px, r2_px;
    logic signed [COEF_WIDTH-1:0]  r2a_b, r2_b;
    logic signed [CONST_WIDTH-1:0] r2a_c, r2_c;
    t_ctl                          r2a_ctl, r2_ctl;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2a_dyp <= r1_dyp;
            r2a_s   <= r1_s;
            r2a_px  <= r1_px;
            r2a_b   <= r1_b;
            r2a_c   <= r1_c;
            r2a_ctl <= r1_ctl;
        end
        if (en[2]) begin
            r2_dyp <= r2a_dyp;
            r2_s   <= r2a_s;
            r2_px  <= r2a_px;
            r2_b   <= r2a_b;
            r2_c   <= r2a_c;
            r2_ctl <= r2a_ctl;
        end
    end

    // stage 3: reductions and the fast tests
    logic signed [D2W-1:0]        n_d2;
    logic signed [BIAS_WIDTH-1:0] n_k;
    logic signed [VW-1:0]         v_sc, v_ap, n_v;
    logic signed [F1W-1:0]        f1_l, f1_r;
    logic signed [F2W-1:0]        f2_l, f2_r;
    logic                         lt1, ab;
    t_ctl                         n_c3;

    always_comb begin
        n_d2 = D2W'(p_xx) - D2W'(p_yy);
        // the unit part of 1+b^2 is folded into the dyp*(dxs+2*dxp) term
        n_k  = p_bb;
        v_sc = VW'(r2_s) - (VW'(r2_c) <<< 1);
        v_ap = VW'(p_ap);
        n_v  = (v_sc <<< FRAC_SHIFT) + (v_ap <<< 1);
        f1_l = F1W'(r2_dyp) <<< FRAC_SHIFT;
        f1_r = F1W'(p_bdx);
        lt1  = f1_l < f1_r;
        f2_l = F2W'(r2_c) <<< FRAC_SHIFT;
        f2_r = (F2W'(r2_px) <<< FRAC_SHIFT) + F2W'(p_pyb);
        ab   = f2_l < f2_r;
        n_c3 = r2_ctl;
        if (r2_ctl.rs ^ r2_ctl.negb) begin
            n_c3.above_f = !lt1;
            n_c3.fast    = !lt1;
        end else begin
            n_c3.above_f = ab ^ r2_ctl.negb;
            n_c3.fast    = !(ab ^ r2_ctl.negb);
        end
    end

    logic signed [D2W-1:0]         r3_d2;
    logic signed [BIAS_WIDTH-1:0]  r3_k;
    logic signed [VW-1:0]          r3_v;
    logic signed [DW-1:0]          r3_dyp;
    logic signed [COEF_WIDTH-1:0]  r3_b;
    logic signed [2*DW-1:0]        r3_dsdy, r3_xx, r4a_xx, r4_xx;
    logic signed [DW+EW-1:0]       r3_e, r4a_e, r4_e;
    t_ctl                          r3_ctl, r4a_ctl, r4_ctl;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_d2   <= n_d2;
            r3_k    <= n_k;
            r3_v    <= n_v;
            r3_dyp  <= r2_dyp;
            r3_b    <= r2_b;
            r3_dsdy <= p_dsdy;
            r3_xx   <= p_xx;
            r3_e    <= p_e;
            r3_ctl  <= n_c3;
        end
        if (en[4]) begin
            r4a_xx  <= r3_xx;
            r4a_e   <= r3_e;
            r4a_ctl <= r3_ctl;
        end
        if (en[5]) begin
            r4_xx  <= r4a_xx;
            r4_e   <= r4a_e;
            r4_ctl <= r4a_ctl;
        end
    end

    // stages 4-5: wide products
    logic signed [COEF_WIDTH+D2W-1:0] q1;
    logic signed [2*DW+BIAS_WIDTH-1:0] q2;
    logic signed [VW+DW-1:0]          q3;

    hpst_mul #(.AW(D2W), .BW(COEF_WIDTH)) u_mq1 (
        .i_clk(i_clk), .i_en_pp(en[4]), .i_en_sum(en[5]),
        .i_a(r3_d2), .i_b(r3_b), .o_p(q1));
    hpst_mul #(.AW(2*DW), .BW(BIAS_WIDTH)) u_mq2 (
        .i_clk(i_clk), .i_en_pp(en[4]), .i_en_sum(en[5]),
        .i_a(r3_dsdy), .i_b(r3_k), .o_p(q2));
    hpst_mul #(.AW(VW), .BW(DW)) u_mq3 (
        .i_clk(i_clk), .i_en_pp(en[4]), .i_en_sum(en[5]),
        .i_a(r3_v), .i_b(r3_dyp), .o_p(q3));

    // stage 6: exact compares and result
    logic signed [LA-1:0] lhs_a, rhs_a;
    logic signed [LB-1:0] lhs_b, rhs_b;
    logic                 lt_a, lt_b, above, n_res;

    always_comb begin
        lhs_a = LA'(q1) <<< FRAC_SHIFT;
        // a zero site x-difference zeroes the whole right-hand side
        rhs_a = r4_ctl.dxs_nz ? (LA'(q2) + (LA'(r4_e) <<< BIAS_SHIFT)) : '0;
        lt_a  = lhs_a < rhs_a;
        lhs_b = LB'(r4_xx) <<< FRAC_SHIFT;
        rhs_b = LB'(q3);
        lt_b  = lhs_b < rhs_b;
        if (r4_ctl.aone) begin
            above = r4_ctl.fast ? r4_ctl.above_f : (lt_a ^ r4_ctl.negb);
        end else begin
            above = lt_b;
        end
        n_res = r4_ctl.quick ? r4_ctl.qval : (above ^ r4_ctl.side);
    end

    logic r_res;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_res <= n_res;
        end
    end

    assign o_rsp.valid   = r_v[NST-1];
    assign o_rsp.left_of = r_res;

    // checks
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("output valid after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_v[0])
        else $error("accepted transaction not captured");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-1] && !o_rsp.ready && r_v[NST-2] |=> r_v[NST-2])
        else $error("stalled transaction dropped");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-2] && en[NST-1] && r4_ctl.quick |=> o_rsp.left_of == $past(r4_ctl.qval))
        else $error("quick rejection result wrong");

endmodule

`default_nettype wire

// ===== tb/sv/tb_halfedge_point_side_test.sv =====
// Testbench for halfedge_point_side_test: random and directed transactions
// checked against an exact wide-integer side predictor.
// Depends on hpst_pkg, hpst_req_if, hpst_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb_halfedge_point_side_test;
    import hpst_pkg::*;

    localparam int CW = DEFAULT_COORD_WIDTH;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_RANDOM = 1400;

    typedef struct {
        logic [CW-1:0]          point_x;
        logic [CW-1:0]          point_y;
        logic [CW-1:0]          top_site_x;
        logic [CW-1:0]          top_site_y;
        logic [CW-1:0]          left_site_x;
        logic [COEF_WIDTH-1:0]  line_a;
        logic [COEF_WIDTH-1:0]  line_b;
        logic [CONST_WIDTH-1:0] line_c;
        logic                   edge_side;
    } query_t;

    logic i_clk;
    logic i_rst_n;

    hpst_req_if #(.COORD_WIDTH(CW)) req_if ();
    hpst_rsp_if rsp_if ();

    halfedge_point_side_test #(.COORD_WIDTH(CW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    query_t pending_q[$];
    logic   left_of_q[$];
    int     err_cnt = 0;
    int     cycle_cnt = 0;
    bit     req_fired = 0;
    int     send_gap = 0;
    int     stall_cnt = 0;
    bit     quiet_mode = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Exact side predicate, all terms in 256-bit two's complement.
    function automatic logic calc_left_of(query_t q);
        logic signed [255:0] px, py, tx, ty, lx, a, b, c;
        logic signed [255:0] dxp, dyp, dxs, one30, lhs, rhs, d2, k, yl, t1, t2, t3;
        logic rs, negb, fast, above;
        px = $signed(q.point_x);
        py = $signed(q.point_y);
        tx = $signed(q.top_site_x);
        ty = $signed(q.top_site_y);
        lx = $signed(q.left_site_x);
        a  = $signed(q.line_a);
        b  = $signed(q.line_b);
        c  = $signed(q.line_c);
        one30 = 256'sh4000_0000;
        rs  = px > tx;
        dxp = px - tx;
        dyp = py - ty;
        dxs = tx - lx;
        if (rs && !q.edge_side) return 1'b1;
        if (!rs && q.edge_side) return 1'b0;
        if (a == one30) begin
            negb = b < 0;
            fast = 0;
            if ((!rs && negb) || (rs && !negb)) begin
                above = !(dyp * one30 < b * dxp);
                fast = above;
            end else begin
                lhs = px * one30 + py * b;
                above = c * one30 < lhs;
                if (negb) above = !above;
                if (!above) fast = 1;
            end
            if (!fast) begin
                d2  = dxp * dxp - dyp * dyp;
                lhs = b * d2 * one30;
                rhs = 0;
                // zero site x-difference: saturated quotient times zero
                if (dxs != 0) begin
                    k = 256'sh1000_0000_0000_0000 + b * b;
                    rhs = dxs * dyp * k + (2 * dxp) * dyp * 256'sh1000_0000_0000_0000;
                end
                above = lhs < rhs;
                if (negb) above = !above;
            end
        end else begin
            yl = c * one30 - a * px;
            t1 = py * one30 - yl;
            t2 = dxp * one30;
            t3 = yl - ty * one30;
            above = (t2 * t2 + t3 * t3) < t1 * t1;
        end
        return q.edge_side ? !above : above;
    endfunction

    function automatic logic [CW-1:0] rand_coord(bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic query_t make_query(bit wide);
        query_t q;
        int r;
        logic [CW-1:0] cv;
        q.point_x     = rand_coord(wide);
        q.point_y     = rand_coord(wide);
        q.top_site_x  = rand_coord(wide);
        q.top_site_y  = rand_coord(wide);
        q.left_site_x = ($urandom_range(0, 9) == 0) ? q.top_site_x : rand_coord(wide);
        if ($urandom_range(0, 9) == 0) q.point_x = q.top_site_x;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            q.line_a = A_ONE;
            q.line_b = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        end else if (r < 90) begin
            q.line_a = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            q.line_b = A_ONE;
        end else begin
            q.line_a = $urandom;
            q.line_b = $urandom;
        end
        if (wide) begin
            q.line_c = CONST_WIDTH'({$urandom, $urandom});
        end else begin
            cv = rand_coord(0);
            q.line_c = {{(CONST_WIDTH-CW){cv[CW-1]}}, cv};
        end
        q.edge_side = 1'($urandom_range(0, 1));
        return q;
    endfunction

    function automatic query_t make_fixed(logic [CW-1:0] px, logic [CW-1:0] py,
                                          logic [CW-1:0] tx, logic [CW-1:0] ty,
                                          logic [CW-1:0] lx, logic [COEF_WIDTH-1:0] a,
                                          logic [COEF_WIDTH-1:0] b,
                                          logic [CONST_WIDTH-1:0] c, logic s);
        query_t q;
        q.point_x = px; q.point_y = py; q.top_site_x = tx; q.top_site_y = ty;
        q.left_site_x = lx; q.line_a = a; q.line_b = b; q.line_c = c; q.edge_side = s;
        return q;
    endfunction

    // Driver: inputs change on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 0;
            rsp_if.ready <= 0;
        end else begin
            if (!req_if.valid || req_fired) begin
                if (send_gap > 0 && !quiet_mode) begin
                    send_gap--;
                    req_if.valid <= 0;
                end else if (pending_q.size() > 0) begin
                    query_t q;
                    q = pending_q.pop_front();
                    req_if.point_x     <= q.point_x;
                    req_if.point_y     <= q.point_y;
                    req_if.top_site_x  <= q.top_site_x;
                    req_if.top_site_y  <= q.top_site_y;
                    req_if.left_site_x <= q.left_site_x;
                    req_if.line_a      <= q.line_a;
                    req_if.line_b      <= q.line_b;
                    req_if.line_c      <= q.line_c;
                    req_if.edge_side   <= q.edge_side;
                    req_if.valid       <= 1;
                    send_gap = rand_gap();
                end else begin
                    req_if.valid <= 0;
                end
            end
            if (quiet_mode) begin
                rsp_if.ready <= 1;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                rsp_if.ready <= 0;
            end else begin
                stall_cnt = rand_gap();
                rsp_if.ready <= (stall_cnt == 0);
            end
            if ($urandom_range(0, 299) == 0) quiet_mode = !quiet_mode;
        end
    end

    // Monitor: sample on the rising edge.
    always @(posedge i_clk) begin
        cycle_cnt++;
        req_fired = 0;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                query_t q;
                q.point_x = req_if.point_x; q.point_y = req_if.point_y;
                q.top_site_x = req_if.top_site_x; q.top_site_y = req_if.top_site_y;
                q.left_site_x = req_if.left_site_x; q.line_a = req_if.line_a;
                q.line_b = req_if.line_b; q.line_c = req_if.line_c;
                q.edge_side = req_if.edge_side;
                left_of_q.push_back(calc_left_of(q));
                req_fired = 1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (left_of_q.size() == 0) begin
                    $error("left_of: unexpected transaction, actual %0b", rsp_if.left_of);
                    err_cnt++;
                end else begin
                    logic want;
                    want = left_of_q.pop_front();
                    if (rsp_if.left_of !== want) begin
                        $error("left_of: expected %0b actual %0b", want, rsp_if.left_of);
                        err_cnt++;
                    end
                end
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL halfedge_point_side_test");
            $finish;
        end
    end

    initial begin
        // drive every input to a known value before reset
        req_if.valid = 0; req_if.point_x = 0; req_if.point_y = 0;
        req_if.top_site_x = 0; req_if.top_site_y = 0; req_if.left_site_x = 0;
        req_if.line_a = 0; req_if.line_b = 0; req_if.line_c = 0; req_if.edge_side = 0;
        rsp_if.ready = 0;
        i_rst_n = 0;

        // quick rejections, both sides
        pending_q.push_back(make_fixed(32'h0002_0000, 0, 32'h0001_0000, 0, 0, A_ONE, 0, 0, 0));
        pending_q.push_back(make_fixed(0, 0, 32'h0001_0000, 0, 0, A_ONE, 0, 0, 1));
        // a equals one: fast slope, exact test, negative b
        pending_q.push_back(make_fixed(32'h0003_0000, 32'h0005_0000, 32'h0001_0000,
                                       0, 0, A_ONE, 32'h2000_0000, 48'h0002_0000, 1));
        pending_q.push_back(make_fixed(32'h0003_0000, 32'hFFFB_0000, 32'h0001_0000,
                                       0, 0, A_ONE, 32'h2000_0000, 48'h0002_0000, 1));
        pending_q.push_back(make_fixed(0, 32'h0004_0000, 32'h0001_0000, 0,
                                       32'hFFFF_0000, A_ONE, 32'hE000_0000, 0, 0));
        pending_q.push_back(make_fixed(0, 32'hFFFC_0000, 32'h0001_0000, 0,
                                       32'hFFFF_0000, A_ONE, 32'hC000_0000, 0, 0));
        pending_q.push_back(make_fixed(0, 32'h0004_0000, 32'h0001_0000, 0,
                                       32'hFFFF_0000, A_ONE, 32'h4000_0000, 48'h7FFF_FFFF_FFFF, 0));
        // zero site x-difference
        pending_q.push_back(make_fixed(0, 32'h0003_0000, 32'h0001_0000, 0,
                                       32'h0001_0000, A_ONE, 32'h1000_0000, 0, 0));
        pending_q.push_back(make_fixed(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 0,
                                       32'h0001_0000, A_ONE, 32'hF000_0000, 0, 1));
        // b equals one, squared distances
        pending_q.push_back(make_fixed(0, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000,
                                       0, 32'h1000_0000, A_ONE, 48'h0001_0000, 0));
        pending_q.push_back(make_fixed(32'h0002_0000, 32'hFFFB_0000, 32'h0001_0000, 0,
                                       0, 32'hC000_0000, A_ONE, 48'h8000_0000_0000, 1));
        // coefficients out of range, field extremes
        pending_q.push_back(make_fixed(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 48'h8000_0000_0000, 0));
        pending_q.push_back(make_fixed(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h8000_0000, 48'h7FFF_FFFF_FFFF, 1));
        pending_q.push_back(make_fixed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF,
                                       A_ONE, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 0));
        pending_q.push_back(make_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h8000_0000, 32'h7FFF_FFFF, A_ONE,
                                       32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1));
        for (int i = 0; i < N_RANDOM; i++)
            pending_q.push_back(make_query($urandom_range(0, 4) == 0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        while (pending_q.size() > 0 || req_if.valid || left_of_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS halfedge_point_side_test");
        else
            $display("FAIL halfedge_point_side_test");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hpst_pkg.sv
design/hpst_req_if.sv
design/hpst_rsp_if.sv
design/hpst_mul.sv
design/halfedge_point_side_test.sv
tb/sv/tb_halfedge_point_side_test.sv
